// ===== hw/rtl/hvws_pkg.sv =====
// ----------------------------------------------------------------------------
// hvws_pkg
// Types, constants and helpers shared by the high-voltage wiper regulator.
// ----------------------------------------------------------------------------
package hvws_pkg;

	localparam int CHANNELS  = 4;
	localparam int WIPER_MAX = 1023;
	localparam int INIT_WIPER = (WIPER_MAX < 1000) ? WIPER_MAX : 1000;

	localparam int CH_W    = 2;
	localparam int V_W     = 20;
	localparam int BAND_W  = 16;
	localparam int WIPER_W = $clog2(WIPER_MAX + 1);
	localparam int PROD_W  = WIPER_W + V_W;
	localparam int WIDE_W  = PROD_W + 2;
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic signed [WIDE_W-1:0] WMAX_WIDE = WIDE_W'(WIPER_MAX);

	typedef enum logic [1:0] {
		REG_TARGET = 2'd0,
		REG_FINE   = 2'd1,
		REG_COARSE = 2'd2,
		REG_DEAD   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ACT_PRIME    = 1'b0,
		ACT_REGULATE = 1'b1
	} action_t;

	typedef struct packed {
		logic               action;
		logic [CH_W-1:0]    channel;
		logic [V_W-1:0]     measured_voltage;
	} in_beat_t;

	typedef struct packed {
		logic [CH_W-1:0]    out_channel;
		logic [WIPER_W-1:0] wiper_value;
	} out_beat_t;

	function automatic logic [WIPER_W-1:0] clamp_wiper(input logic signed [WIDE_W-1:0] w);
		logic [WIPER_W-1:0] r;
		if (w < 0) begin
			r = '0;
		end else if (w > WMAX_WIDE) begin
			r = WIPER_W'(WIPER_MAX);
		end else begin
			r = w[WIPER_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hv_wiper_secant_regulator.sv =====
// ----------------------------------------------------------------------------
// hv_wiper_secant_regulator
// Per-channel wiper regulator: fixed steps near target, else secant/saturation.
// ----------------------------------------------------------------------------
// A prime beat runs CALC, DONE; a regulate beat near target or with no
// voltage change runs CALC, MUL, DONE; a secant step adds the 30-step
// divider (one quotient bit per cycle) before DONE. The next beat can be
// taken after the result loads; req_stall is high while busy or result waits.
// A finished result waits in the output register while the next beat runs.
// Reset restores register defaults and all channel wiper/voltage history.
module hv_wiper_secant_regulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  hvws_pkg::in_beat_t             req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output hvws_pkg::out_beat_t            rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hvws_pkg::ADDR_W-1:0]    paddr,
	input  logic [hvws_pkg::DATA_W-1:0]    pwdata,
	output logic [hvws_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam int CH  = hvws_pkg::CHANNELS;
	localparam int CW  = hvws_pkg::CH_W;
	localparam int VW  = hvws_pkg::V_W;
	localparam int BW  = hvws_pkg::BAND_W;
	localparam int WW  = hvws_pkg::WIPER_W;
	localparam int PW  = hvws_pkg::PROD_W;
	localparam int XW  = hvws_pkg::WIDE_W;
	localparam int NW  = hvws_pkg::CNT_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CALC = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [VW-1:0] target_q;
	logic [BW-1:0] fine_q, coarse_q, dead_q;

	logic [VW-1:0] prev_v_q [CH];
	logic [WW-1:0] prev_w_q [CH];
	logic [WW-1:0] cur_w_q  [CH];

	logic          act_q;
	logic [CW-1:0] ch_q;
	logic [VW-1:0] meas_q;

	logic [VW-1:0] ae_q, vmag_q;
	logic [WW-1:0] dmag_q, cur_q, w_q;
	logic          e_neg_q, d_neg_q, v_neg_q, neg_q, fix_q;
	logic [VW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [NW-1:0] cnt_q;

	logic          out_valid_q;
	hvws_pkg::out_beat_t out_q;

	logic          req_acc, cfg_wr, out_free;
	logic          ch_ok;

	// calc stage operands
	logic [VW-1:0] c_prev_v;
	logic [WW-1:0] c_prev_w, c_cur;
	logic          c_e_neg, c_v_neg, c_d_neg;
	logic [VW-1:0] c_ae, c_vmag;
	logic [WW-1:0] c_dmag;

	// mul stage
	logic [PW-1:0]          prod;
	logic signed [XW-1:0]   cur_wide, step_wide, fine_w;

	// divider step
	logic [VW:0]   rem_sh;
	logic [VW+1:0] diff;
	logic          qbit;

	// fix stage
	logic signed [XW-1:0]   q_wide, sec_w;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign req_stall = (state_q != S_IDLE);
	assign req_acc  = req_valid && !req_stall;
	assign ch_ok    = (int'(req.channel) < CH);
	assign out_free = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		case (hvws_pkg::reg_idx_t'(paddr[3:2]))
			hvws_pkg::REG_TARGET: prdata = hvws_pkg::DATA_W'(target_q);
			hvws_pkg::REG_FINE:   prdata = hvws_pkg::DATA_W'(fine_q);
			hvws_pkg::REG_COARSE: prdata = hvws_pkg::DATA_W'(coarse_q);
			hvws_pkg::REG_DEAD:   prdata = hvws_pkg::DATA_W'(dead_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= VW'(380000);
			fine_q   <= BW'(1000);
			coarse_q <= BW'(150);
			dead_q   <= BW'(60);
		end else if (cfg_wr) begin
			case (hvws_pkg::reg_idx_t'(paddr[3:2]))
				hvws_pkg::REG_TARGET: target_q <= pwdata[VW-1:0];
				hvws_pkg::REG_FINE:   fine_q   <= pwdata[BW-1:0];
				hvws_pkg::REG_COARSE: coarse_q <= pwdata[BW-1:0];
				hvws_pkg::REG_DEAD:   dead_q   <= pwdata[BW-1:0];
				default: ;
			endcase
		end
	end

	// operand magnitudes and signs
	always_comb begin
		c_prev_v = prev_v_q[ch_q];
		c_prev_w = prev_w_q[ch_q];
		c_cur    = cur_w_q[ch_q];
		c_e_neg  = meas_q < target_q;
		c_ae     = c_e_neg ? (target_q - meas_q) : (meas_q - target_q);
		c_v_neg  = c_prev_v < meas_q;
		c_vmag   = c_v_neg ? (meas_q - c_prev_v) : (c_prev_v - meas_q);
		if (c_prev_w == c_cur) begin
			c_d_neg = 1'b0;
			c_dmag  = WW'(1);
		end else begin
			c_d_neg = c_prev_w < c_cur;
			c_dmag  = c_d_neg ? (c_cur - c_prev_w) : (c_prev_w - c_cur);
		end
	end

	always_comb begin
		prod     = PW'(dmag_q) * PW'(ae_q);
		cur_wide = XW'(cur_q);
		if (ae_q > VW'(dead_q)) begin
			step_wide = (ae_q > VW'(coarse_q)) ? XW'(2) : XW'(1);
		end else begin
			step_wide = '0;
		end
		fine_w = e_neg_q ? (cur_wide - step_wide) : (cur_wide + step_wide);
	end

	always_comb begin
		rem_sh = {rem_q, quo_q[PW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, vmag_q};
		qbit   = !diff[VW+1];
	end

	always_comb begin
		q_wide = XW'(quo_q);
		sec_w  = neg_q ? (cur_wide + q_wide) : (cur_wide - q_wide);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			for (int i = 0; i < CH; i++) begin
				prev_v_q[i] <= '0;
				prev_w_q[i] <= WW'(hvws_pkg::WIPER_MAX);
				cur_w_q[i]  <= WW'(hvws_pkg::INIT_WIPER);
			end
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc && ch_ok) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (act_q == hvws_pkg::ACT_PRIME) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (ae_q < VW'(fine_q) || vmag_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + NW'(1);
					if (cnt_q == NW'(PW - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						if (act_q == hvws_pkg::ACT_PRIME) begin
							prev_w_q[ch_q] <= WW'(hvws_pkg::WIPER_MAX);
							cur_w_q[ch_q]  <= WW'(hvws_pkg::INIT_WIPER);
						end else begin
							prev_w_q[ch_q] <= cur_q;
							cur_w_q[ch_q]  <= fix_q ? hvws_pkg::clamp_wiper(sec_w) : w_q;
						end
						prev_v_q[ch_q] <= meas_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					act_q  <= req.action;
					ch_q   <= req.channel;
					meas_q <= req.measured_voltage;
				end
			end
			S_CALC: begin
				ae_q    <= c_ae;
				e_neg_q <= c_e_neg;
				vmag_q  <= c_vmag;
				v_neg_q <= c_v_neg;
				dmag_q  <= c_dmag;
				d_neg_q <= c_d_neg;
				cur_q   <= c_cur;
				fix_q   <= 1'b0;
				w_q     <= WW'(hvws_pkg::INIT_WIPER);
			end
			S_MUL: begin
				if (ae_q < VW'(fine_q)) begin
					w_q <= hvws_pkg::clamp_wiper(fine_w);
				end else if (vmag_q == '0) begin
					// zero voltage change: step saturates with sign of d*e
					if (ae_q == '0) begin
						w_q <= cur_q;
					end else if (d_neg_q == e_neg_q) begin
						w_q <= '0;
					end else begin
						w_q <= WW'(hvws_pkg::WIPER_MAX);
					end
				end else begin
					rem_q <= '0;
					quo_q <= prod;
					neg_q <= d_neg_q ^ e_neg_q ^ v_neg_q;
					fix_q <= 1'b1;
				end
			end
			S_DIV: begin
				rem_q <= qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
				quo_q <= {quo_q[PW-2:0], qbit};
			end
			S_DONE: begin
				if (out_free) begin
					out_q.out_channel <= ch_q;
					if (act_q == hvws_pkg::ACT_PRIME) begin
						out_q.wiper_value <= WW'(hvws_pkg::INIT_WIPER);
					end else begin
						out_q.wiper_value <= fix_q ? hvws_pkg::clamp_wiper(sec_w) : w_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/hvws_checker.sv =====
// ----------------------------------------------------------------------------
// hvws_checker
// Port-level checks for the high-voltage wiper regulator, bound to the top.
// ----------------------------------------------------------------------------
module hvws_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input hvws_pkg::in_beat_t  req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input hvws_pkg::out_beat_t rsp
);

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// an accepted beat for a valid channel makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (int'(req.channel) < hvws_pkg::CHANNELS) |=> req_stall)
		else $error("block not busy after accepting a beat");

	// a new result only appears after the block was working
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result beat without work in progress");

	// wiper stays in range
	a_wiper_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.wiper_value) <= hvws_pkg::WIPER_MAX))
		else $error("wiper value out of range");

endmodule

bind hv_wiper_secant_regulator hvws_checker u_hvws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== verif/hv_wiper_secant_regulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hv_wiper_secant_regulator_test
// Self-checking bench for the wiper regulator. A scoreboard tracks register
// values and per-channel voltage/wiper history and predicts each result beat.
// A short directed set covers hold, fixed steps, secant steps and the zero
// voltage change cases. Random phases then sweep register settings, request
// idling and result stalls on all four channels.
// ----------------------------------------------------------------------------
module hv_wiper_secant_regulator_test;

	localparam int V_MAX          = 2**hvws_pkg::V_W - 1;
	localparam int TIMEOUT_CYCLES = 400000;

	class wiper_scoreboard;
		logic [hvws_pkg::V_W-1:0]    target_mv;
		logic [hvws_pkg::BAND_W-1:0] fine_mv;
		logic [hvws_pkg::BAND_W-1:0] coarse_mv;
		logic [hvws_pkg::BAND_W-1:0] dead_mv;
		longint                      last_mv[hvws_pkg::CHANNELS];
		longint                      last_wiper[hvws_pkg::CHANNELS];
		longint                      wiper[hvws_pkg::CHANNELS];
		hvws_pkg::out_beat_t         expected_wipers[$];
		int                          errors;

		function new();
			target_mv = hvws_pkg::V_W'(380000);
			fine_mv   = hvws_pkg::BAND_W'(1000);
			coarse_mv = hvws_pkg::BAND_W'(150);
			dead_mv   = hvws_pkg::BAND_W'(60);
			errors    = 0;
			for (int i = 0; i < hvws_pkg::CHANNELS; i++) begin
				last_mv[i]    = 0;
				last_wiper[i] = hvws_pkg::WIPER_MAX;
				wiper[i]      = hvws_pkg::INIT_WIPER;
			end
		endfunction

		function void write_reg(hvws_pkg::reg_idx_t idx, logic [hvws_pkg::DATA_W-1:0] value);
			case (idx)
				hvws_pkg::REG_TARGET: begin
					target_mv = value[hvws_pkg::V_W-1:0];
				end
				hvws_pkg::REG_FINE: begin
					fine_mv = value[hvws_pkg::BAND_W-1:0];
				end
				hvws_pkg::REG_COARSE: begin
					coarse_mv = value[hvws_pkg::BAND_W-1:0];
				end
				hvws_pkg::REG_DEAD: begin
					dead_mv = value[hvws_pkg::BAND_W-1:0];
				end
				default: ;
			endcase
		endfunction

		function longint next_wiper_setting(int ch, longint mv);
			longint cur, d, e, ae, v, w, s, p;
			cur = wiper[ch];
			d   = last_wiper[ch] - cur;
			e   = mv - longint'(target_mv);
			ae  = (e < 0) ? -e : e;
			v   = last_mv[ch] - mv;
			if (d == 0) begin
				d = 1;
			end
			if (ae < longint'(fine_mv)) begin
				s = 0;
				if (ae > longint'(dead_mv)) begin
					s = (ae > longint'(coarse_mv)) ? 2 : 1;
				end
				w = (e < 0) ? cur - s : cur + s;
			end else if (v == 0) begin
				// step saturates with the sign of d*e
				p = d * e;
				if (p > 0) begin
					w = 0;
				end else if (p < 0) begin
					w = hvws_pkg::WIPER_MAX;
				end else begin
					w = cur;
				end
			end else begin
				w = cur - (d * e) / v;
			end
			if (w < 0) begin
				w = 0;
			end else if (w > hvws_pkg::WIPER_MAX) begin
				w = hvws_pkg::WIPER_MAX;
			end
			return w;
		endfunction

		function void note_input(hvws_pkg::in_beat_t b);
			int                  ch;
			longint              mv;
			longint              w;
			hvws_pkg::out_beat_t want;
			ch = b.channel;
			mv = b.measured_voltage;
			if (ch >= hvws_pkg::CHANNELS) begin
				return;
			end
			if (hvws_pkg::action_t'(b.action) == hvws_pkg::ACT_PRIME) begin
				last_mv[ch]    = mv;
				last_wiper[ch] = hvws_pkg::WIPER_MAX;
				wiper[ch]      = hvws_pkg::INIT_WIPER;
			end else begin
				w              = next_wiper_setting(ch, mv);
				last_wiper[ch] = wiper[ch];
				wiper[ch]      = w;
				last_mv[ch]    = mv;
			end
			want.out_channel = b.channel;
			want.wiper_value = hvws_pkg::WIPER_W'(wiper[ch]);
			expected_wipers.push_back(want);
		endfunction

		function void check_result(hvws_pkg::out_beat_t r);
			hvws_pkg::out_beat_t want;
			if (expected_wipers.size() == 0) begin
				$error("unexpected out beat: out_channel %0d wiper_value %0d",
					r.out_channel, r.wiper_value);
				errors++;
				return;
			end
			want = expected_wipers.pop_front();
			if (r.out_channel !== want.out_channel) begin
				$error("out_channel: expected %0d, got %0d", want.out_channel, r.out_channel);
				errors++;
			end
			if (r.wiper_value !== want.wiper_value) begin
				$error("wiper_value: expected %0d, got %0d", want.wiper_value, r.wiper_value);
				errors++;
			end
		endfunction
	endclass

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	hvws_pkg::in_beat_t              req       = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	hvws_pkg::out_beat_t             rsp;
	logic                            psel      = 1'b0;
	logic                            penable   = 1'b0;
	logic                            pwrite    = 1'b0;
	logic [hvws_pkg::ADDR_W-1:0]     paddr     = '0;
	logic [hvws_pkg::DATA_W-1:0]     pwdata    = '0;
	logic [hvws_pkg::DATA_W-1:0]     prdata;
	logic                            pready;

	wiper_scoreboard     sb;
	int                  send_idle_pct = 0;
	int                  stall_pct     = 0;
	int unsigned         cycle_count   = 0;
	int                  gen_last_mv[hvws_pkg::CHANNELS];

	hv_wiper_secant_regulator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				sb.note_input(req);
			end
			if (rsp_valid && !rsp_stall) begin
				sb.check_result(rsp);
			end
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int near_target(int spread);
		int mv;
		mv = int'(sb.target_mv) + int'($urandom_range(2 * spread)) - spread;
		if (mv < 0) begin
			mv = 0;
		end else if (mv > V_MAX) begin
			mv = V_MAX;
		end
		return mv;
	endfunction

	task automatic send_beat(hvws_pkg::action_t act, int ch, int mv);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= hvws_pkg::in_beat_t'{action: act, channel: hvws_pkg::CH_W'(ch),
			measured_voltage: hvws_pkg::V_W'(mv)};
		gen_last_mv[ch] = mv;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_wipers.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(hvws_pkg::reg_idx_t idx, int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= hvws_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_regs(int tgt, int fb, int cb, int db);
		write_reg(hvws_pkg::REG_TARGET, tgt);
		write_reg(hvws_pkg::REG_FINE, fb);
		write_reg(hvws_pkg::REG_COARSE, cb);
		write_reg(hvws_pkg::REG_DEAD, db);
	endtask

	// mostly prime-then-regulate runs near the target, some raw noise
	task automatic run_random(int count);
		int ch, n, mv;
		while (count > 0) begin
			if ($urandom_range(99) < 80) begin
				ch = $urandom_range(hvws_pkg::CHANNELS - 1);
				if ($urandom_range(3) == 0) begin
					mv = $urandom_range(V_MAX);
				end else begin
					mv = near_target(int'(sb.fine_mv) * 4 + 1000);
				end
				send_beat(hvws_pkg::ACT_PRIME, ch, mv);
				count--;
				n = $urandom_range(8, 2);
				repeat (n) begin
					case ($urandom_range(4))
						0: begin
							mv = gen_last_mv[ch];
						end
						1: begin
							mv = near_target(60000);
						end
						default: begin
							mv = near_target(int'(sb.fine_mv) * 2 + 300);
						end
					endcase
					send_beat(hvws_pkg::ACT_REGULATE, ch, mv);
					count--;
				end
			end else begin
				send_beat(hvws_pkg::action_t'($urandom_range(1)),
					$urandom_range(hvws_pkg::CHANNELS - 1), $urandom_range(V_MAX));
				count--;
			end
		end
	endtask

	initial begin
		int tgt, fb, cb, db;
		sb = new();
		for (int i = 0; i < hvws_pkg::CHANNELS; i++) begin
			gen_last_mv[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_beat(hvws_pkg::ACT_PRIME, 0, 380000);
		send_beat(hvws_pkg::ACT_REGULATE, 0, 380000);
		send_beat(hvws_pkg::ACT_REGULATE, 0, 385000);
		send_beat(hvws_pkg::ACT_REGULATE, 0, 380050);
		send_beat(hvws_pkg::ACT_REGULATE, 0, 380100);
		send_beat(hvws_pkg::ACT_REGULATE, 0, 379800);
		send_beat(hvws_pkg::ACT_PRIME, 1, V_MAX);
		send_beat(hvws_pkg::ACT_REGULATE, 1, V_MAX);
		send_beat(hvws_pkg::ACT_PRIME, 2, 0);
		send_beat(hvws_pkg::ACT_REGULATE, 2, 0);
		send_beat(hvws_pkg::ACT_PRIME, 3, 300000);
		send_beat(hvws_pkg::ACT_REGULATE, 3, 370000);
		send_beat(hvws_pkg::ACT_REGULATE, 3, 400000);
		send_beat(hvws_pkg::ACT_REGULATE, 3, 390500);
		send_beat(hvws_pkg::ACT_REGULATE, 3, 0);
		send_beat(hvws_pkg::ACT_REGULATE, 3, V_MAX);
		drain();

		// zero fine band: zero error with zero voltage change holds
		set_regs(380000, 0, 150, 60);
		send_beat(hvws_pkg::ACT_PRIME, 0, 380000);
		send_beat(hvws_pkg::ACT_REGULATE, 0, 380000);
		send_beat(hvws_pkg::ACT_REGULATE, 1, 380000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					set_regs(380000, 1000, 150, 60);
				end
				1: begin
					set_regs(V_MAX, 65535, 65535, 0);
				end
				2: begin
					set_regs(0, 0, 0, 65535);
				end
				4: begin
					set_regs(380000, 1000, 60, 150);
				end
				5: begin
					set_regs($urandom_range(V_MAX), $urandom_range(65535),
						$urandom_range(65535), $urandom_range(65535));
				end
				6: begin
					set_regs(100000, 65535, 0, 0);
				end
				default: begin
					tgt = $urandom_range(V_MAX);
					fb  = $urandom_range(5000, 500);
					cb  = $urandom_range(fb);
					db  = $urandom_range(cb);
					set_regs(tgt, fb, cb, db);
				end
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 47;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 47;
				end
				default: begin
					send_idle_pct = 32;
					stall_pct     = 32;
				end
			endcase
			run_random(56);
			drain();
		end

		if (sb.errors == 0 && sb.expected_wipers.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
